// File: hdl/dq_pkg.sv
// Shared types and constants for the double-ended queue.
// Used by dq_cell, double_ended_queue and dq_chk; depends on nothing.
package dq_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  // Operation codes carried on in_op
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_DUMP       = 3'd4;

  // Status codes carried on out_status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Command broadcast to every cell of the row
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_BACK,
    CELL_POP_FRONT,
    CELL_POP_BACK,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [DATA_W-1:0]   value;  // data for a push at the back
    logic [DATA_W-1:0]   head;   // front entry, recirculated on rotate
  } cell_cmd_t;

endpackage

// File: hdl/dq_cell.sv
// One storage cell of the queue row: a valid bit and one entry.
// Depends on dq_pkg. Cell 0 is the front; valid bits form a thermometer.
module dq_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dq_pkg::cell_cmd_t         cmd,
  input  logic                      prev_v,
  input  logic [dq_pkg::DATA_W-1:0] prev_d,
  input  logic                      next_v,
  input  logic [dq_pkg::DATA_W-1:0] next_d,
  output logic                      v_o,
  output logic [dq_pkg::DATA_W-1:0] d_o
);
  import dq_pkg::*;

  logic              v_r, v_nxt;
  logic [DATA_W-1:0] d_r, d_nxt;
  logic              tail;

  // this cell holds the back entry
  assign tail = v_r && !next_v;

  // next state from the broadcast command and the neighbors
  always_comb begin
    v_nxt = v_r;
    d_nxt = d_r;
    case (cmd.op)
      CELL_PUSH_FRONT: begin
        v_nxt = prev_v;
        d_nxt = prev_d;
      end
      CELL_PUSH_BACK: begin
        if (prev_v && !v_r) begin
          v_nxt = 1'b1;
          d_nxt = cmd.value;
        end
      end
      CELL_POP_FRONT: begin
        v_nxt = next_v;
        d_nxt = next_d;
      end
      CELL_POP_BACK: begin
        v_nxt = v_r && next_v;
      end
      CELL_ROTATE: begin
        d_nxt = tail ? cmd.head : next_d;
      end
      default: begin
        v_nxt = v_r;
        d_nxt = d_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign v_o = v_r;
  assign d_o = d_r;

endmodule

// File: hdl/double_ended_queue.sv
// Top level of the bounded double-ended queue: a row of dq_cell stages
// with a sequencer and an output register. Depends on dq_pkg, dq_cell.
//
// Usage:
//   Input channel in_valid/in_ready carries in_op and in_value. Result
//   channel out_valid/out_ready carries out_status, out_entry, out_last.
//   Entries live in a row of CAPACITY cells, front at cell 0. Pushes and
//   pops shift the whole row by one cell or set/clear the back cell; each
//   gives one result, in the cycle after the input transaction (the
//   result sits in the output register).
//   Throughput: one push or pop per cycle while out_ready stays high.
//   A dump of N entries rotates the row one cell per cycle while out_ready
//   stays high: cell 0 is listed each time, and after N steps the row is
//   back in its original order. in_ready is low until the last entry is
//   listed. An empty dump, a pop on an empty queue and a push on a full
//   queue give one result with a status code; op codes 5 to 7 are taken
//   and give no result.
//   Reset (rst_n low, synchronous) empties the queue and drops any
//   pending result. When the receiver stalls, the result stays in the
//   output register and in_ready drops until it is taken.
module double_ended_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                in_op,
  input  logic signed [31:0]        in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic signed [31:0]        out_entry,
  output logic                      out_last
);
  import dq_pkg::*;

  logic [CAPACITY-1:0]             cell_v;
  logic [DATA_W-1:0]               cell_d [CAPACITY];
  logic [DATA_W-1:0]               tail_data;
  cell_cmd_t                       cmd;

  logic [OCC_W-1:0]                occ_r, occ_nxt;
  logic [IDX_W-1:0]                cnt_r, cnt_nxt;
  logic                            dump_r, dump_nxt;
  logic                            out_valid_r;
  logic [1:0]                      out_status_r;
  logic [DATA_W-1:0]               out_entry_r;
  logic                            out_last_r;

  logic                            slot_free, acc, empty, full;
  logic                            emit;
  logic [1:0]                      emit_status;
  logic [DATA_W-1:0]               emit_entry;
  logic                            emit_last;
  logic [OCC_W-1:0]                occ_m1;

  // the cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic              pv, nv;
    logic [DATA_W-1:0] pd, nd;
    if (i == 0) begin : g_head
      assign pv = 1'b1;
      assign pd = in_value;
    end else begin : g_body
      assign pv = cell_v[i-1];
      assign pd = cell_d[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign nv = 1'b0;
      assign nd = '0;
    end else begin : g_mid
      assign nv = cell_v[i+1];
      assign nd = cell_d[i+1];
    end
    dq_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .prev_v (pv),
      .prev_d (pd),
      .next_v (nv),
      .next_d (nd),
      .v_o    (cell_v[i]),
      .d_o    (cell_d[i])
    );
  end

  // back entry: one-hot tail select over the row
  always_comb begin
    tail_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_v[i] && (i == CAPACITY - 1 || !cell_v[(i + 1) % CAPACITY])) begin
        tail_data = tail_data | cell_d[i];
      end
    end
  end

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = !dump_r && slot_free;
  assign acc       = in_valid && in_ready;
  assign empty     = !cell_v[0];
  assign full      = cell_v[CAPACITY-1];
  assign occ_m1    = occ_r - 1'b1;

  // sequencer: decode the transaction or step a running dump
  always_comb begin
    cmd.op      = CELL_HOLD;
    cmd.value   = in_value;
    cmd.head    = cell_d[0];
    occ_nxt     = occ_r;
    cnt_nxt     = cnt_r;
    dump_nxt    = dump_r;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_entry  = '0;
    emit_last   = 1'b1;
    if (dump_r) begin
      if (slot_free) begin
        cmd.op     = CELL_ROTATE;
        emit       = 1'b1;
        emit_entry = cell_d[0];
        emit_last  = (OCC_W'(cnt_r) == occ_m1);
        cnt_nxt    = cnt_r + 1'b1;
        if (emit_last) begin
          dump_nxt = 1'b0;
        end
      end
    end else if (acc) begin
      case (in_op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          emit = 1'b1;
          if (full) begin
            emit_status = ST_FULL;
          end else begin
            cmd.op  = (in_op == OP_PUSH_FRONT) ? CELL_PUSH_FRONT : CELL_PUSH_BACK;
            occ_nxt = occ_r + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          emit = 1'b1;
          if (empty) begin
            emit_status = ST_EMPTY;
          end else begin
            cmd.op     = CELL_POP_FRONT;
            emit_entry = cell_d[0];
            occ_nxt    = occ_m1;
          end
        end
        OP_POP_BACK: begin
          emit = 1'b1;
          if (empty) begin
            emit_status = ST_EMPTY;
          end else begin
            cmd.op     = CELL_POP_BACK;
            emit_entry = tail_data;
            occ_nxt    = occ_m1;
          end
        end
        OP_DUMP: begin
          emit = 1'b1;
          if (empty) begin
            emit_status = ST_EMPTY;
          end else begin
            cmd.op     = CELL_ROTATE;
            emit_entry = cell_d[0];
            emit_last  = (occ_r == OCC_W'(1));
            cnt_nxt    = IDX_W'(1);
            dump_nxt   = !emit_last;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      cnt_r       <= '0;
      dump_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r  <= occ_nxt;
      cnt_r  <= cnt_nxt;
      dump_r <= dump_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= emit_status;
      out_entry_r  <= emit_entry;
      out_last_r   <= emit_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_entry  = out_entry_r;
  assign out_last   = out_last_r;

endmodule

// File: hdl/dq_chk.sv
// Port-level checker for double_ended_queue, attached by bind below.
// Depends on dq_pkg.
module dq_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [2:0]         in_op,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic signed [31:0] out_entry,
  input logic               out_last
);
  import dq_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_entry) && $stable(out_last))
    else $error("result changed while stalled");

  // no new input transaction while a result is stalled
  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // a defined op code always produces a result on the next cycle
  a_res_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op <= OP_DUMP) |=> out_valid)
    else $error("no result after a defined op");

  // error statuses always close the transaction
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last)
    else $error("error status without last");

  // error statuses carry a zero entry
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_entry == 32'sd0)
    else $error("error status with nonzero entry");

endmodule

bind double_ended_queue dq_chk u_dq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .in_op      (in_op),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_status (out_status),
  .out_entry  (out_entry),
  .out_last   (out_last)
);
